[design/dtcs_pkg.sv]
// Shared types, constants and helper functions for the DDS tuning command sequencer.
// Depends on nothing; every other design file imports it.
package dtcs_pkg;

  localparam int unsigned WORD_W          = 16;
  localparam int unsigned FREQ_W          = 32;
  localparam int unsigned IDX_W           = 3;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam logic [FREQ_W-1:0] MASTER_CLOCK_RESET = 32'd25000000;

  typedef enum logic [1:0] {
    OP_INIT      = 2'd0,
    OP_SET_FREQ  = 2'd1,
    OP_SLEEP_ON  = 2'd2,
    OP_SLEEP_OFF = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_EMIT
  } back_state_t;

  // One queued request, already classified by the front end.
  typedef struct packed {
    op_t                op;
    logic [FREQ_W-1:0]  freq;
    logic               saturate;
  } entry_t;

  localparam logic [WORD_W-1:0] WORD_RESET_CTRL = 16'hF800;
  localparam logic [WORD_W-1:0] WORD_CLEAR_A    = 16'hB000;
  localparam logic [WORD_W-1:0] WORD_CLEAR_B    = 16'hC000;
  localparam logic [WORD_W-1:0] WORD_SLEEP_ON   = 16'hE000;
  localparam logic [WORD_W-1:0] WORD_FREQ_HH    = 16'h3300;
  localparam logic [WORD_W-1:0] WORD_FREQ_HL    = 16'h2200;
  localparam logic [WORD_W-1:0] WORD_FREQ_LH    = 16'h3100;
  localparam logic [WORD_W-1:0] WORD_FREQ_LL    = 16'h2000;
  localparam logic [WORD_W-1:0] WORD_PHASE_A    = 16'h1900;
  localparam logic [WORD_W-1:0] WORD_PHASE_B    = 16'h0800;

  // Index of the final word in the run of a given operation.
  function automatic logic [IDX_W-1:0] last_index(input op_t op);
    logic [IDX_W-1:0] r;
    case (op)
      OP_INIT:     r = 3'd2;
      OP_SET_FREQ: r = 3'd5;
      default:     r = 3'd0;
    endcase
    return r;
  endfunction

  // Command word number idx of the run for op, given the tuning word tw.
  function automatic logic [WORD_W-1:0] command_for(input op_t op,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic [FREQ_W-1:0] tw);
    logic [WORD_W-1:0] w;
    case (op)
      OP_INIT: begin
        case (idx)
          3'd0:    w = WORD_RESET_CTRL;
          3'd1:    w = WORD_CLEAR_A;
          default: w = WORD_CLEAR_B;
        endcase
      end
      OP_SET_FREQ: begin
        case (idx)
          3'd0:    w = WORD_FREQ_HH | {8'h00, tw[31:24]};
          3'd1:    w = WORD_FREQ_HL | {8'h00, tw[23:16]};
          3'd2:    w = WORD_FREQ_LH | {8'h00, tw[15:8]};
          3'd3:    w = WORD_FREQ_LL | {8'h00, tw[7:0]};
          3'd4:    w = WORD_PHASE_A;
          default: w = WORD_PHASE_B;
        endcase
      end
      OP_SLEEP_ON: w = WORD_SLEEP_ON;
      default:     w = WORD_CLEAR_B;
    endcase
    return w;
  endfunction

endpackage

[design/dtcs_front.sv]
// Front end: accepts requests, flags saturating frequencies and queues them.
// Depends on dtcs_pkg.
module dtcs_front import dtcs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        operation,
  input  logic [FREQ_W-1:0] frequency_hz,
  input  logic [FREQ_W-1:0] master_clock_hz,
  input  logic              pop,
  output logic              busy,
  output logic              empty,
  output entry_t            head
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             do_pop;
  entry_t           incoming;

  assign busy   = (count == CNT_FULL);
  assign empty  = (count == '0);
  assign push   = start && !busy;
  assign do_pop = pop && !empty;
  assign head   = slots[rd_ptr];

  // A zero clock register also saturates, since every frequency is at or above it.
  always_comb begin
    incoming.op       = op_t'(operation);
    incoming.freq     = frequency_hz;
    incoming.saturate = (frequency_hz >= master_clock_hz);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/dtcs_divider.sv]
// Restoring divider, one quotient bit per cycle: floor(freq * 2^32 / divisor).
// Requires freq < divisor. Depends on dtcs_pkg.
module dtcs_divider import dtcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [FREQ_W-1:0] freq,
  input  logic [FREQ_W-1:0] divisor,
  output logic              done,
  output logic [FREQ_W-1:0] quotient
);

  localparam int unsigned STEP_W = $clog2(FREQ_W);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [FREQ_W-1:0] remainder;
  logic [FREQ_W-1:0] dvs;
  logic [FREQ_W:0]   shifted;
  logic [FREQ_W:0]   diff;
  logic              fits;

  assign shifted = {remainder, 1'b0};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (go) begin
      remainder <= freq;
      dvs       <= divisor;
    end else if (running) begin
      remainder <= fits ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
      quotient  <= {quotient[FREQ_W-2:0], fits};
    end
  end

  // done pulses for one cycle once the final quotient bit is in the register.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
      done    <= 1'b0;
    end else begin
      done <= running && (step == '0);
      if (go) begin
        running <= 1'b1;
        step    <= STEP_W'(FREQ_W - 1);
      end else if (running) begin
        if (step == '0) begin
          running <= 1'b0;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

endmodule

[design/dtcs_back.sv]
// Back end: takes queued requests, runs the divider and emits the command words.
// Depends on dtcs_pkg and dtcs_divider.
module dtcs_back import dtcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  entry_t            head,
  input  logic [FREQ_W-1:0] master_clock_hz,
  output logic              pop,
  output logic              strobe,
  output logic [WORD_W-1:0] command_word,
  output logic              last_word
);

  back_state_t       state;
  back_state_t       state_next;
  op_t               op;
  logic [IDX_W-1:0]  idx;
  logic [FREQ_W-1:0] tw;
  logic              div_go;
  logic              div_done;
  logic [FREQ_W-1:0] div_quotient;
  logic              at_last;

  dtcs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .freq     (head.freq),
    .divisor  (master_clock_hz),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign at_last      = (idx == last_index(op));
  assign strobe       = (state == BK_EMIT);
  assign command_word = command_for(op, idx, tw);
  assign last_word    = at_last;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    div_go     = 1'b0;
    case (state)
      BK_IDLE: begin
        pop = !empty;
      end
      BK_DIVIDE: begin
        if (div_done) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (at_last) begin
          pop        = !empty;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
    // Launching the next request may follow the final word directly.
    if (pop) begin
      if (head.op == OP_SET_FREQ && !head.saturate) begin
        div_go     = 1'b1;
        state_next = BK_DIVIDE;
      end else begin
        state_next = BK_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op  <= head.op;
      idx <= '0;
      tw  <= '1;
    end else begin
      if (state == BK_EMIT) begin
        idx <= idx + 1'b1;
      end
      if (div_done) begin
        tw <= div_quotient;
      end
    end
  end

endmodule

[design/dds_tuning_command_sequencer_top.sv]
// Top level of the DDS tuning command sequencer: clock register, front end and back end.
// Depends on dtcs_pkg, dtcs_front and dtcs_back.
//
// The block turns each request transaction into the run of 16-bit command words that a
// direct digital synthesiser expects. A transaction is taken at a rising edge where start
// is high and busy is low; busy rises only when the request queue (QUEUE_DEPTH entries,
// two by default) is full, so requests may be issued while earlier ones are still being
// worked on. Each command word appears on command_word for exactly one cycle with strobe
// high and last_word marking the final word of the run; the receiver cannot stall these
// words, so it must take one every cycle that strobe is high. Init gives three words,
// sleep on and sleep off one word each, and set frequency six words. The back end launches
// a request from idle or overlapped with the final word of the previous run, then emits
// one word per cycle. Set frequency first runs a restoring divider that produces one
// quotient bit per cycle and then hands the quotient over as the tuning word before its
// six words; a frequency at or above the master clock (or a zero clock register)
// saturates the tuning word to all ones and skips the divider. The master clock register
// is written with config_write and config_data and resets to 25 MHz; it must only be
// written while no request is outstanding. There is no clearing pass after reset.
module dds_tuning_command_sequencer_top import dtcs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation,
  input  logic [FREQ_W-1:0] frequency_hz,
  input  logic              config_write,
  input  logic [FREQ_W-1:0] config_data,
  output logic              strobe,
  output logic [WORD_W-1:0] command_word,
  output logic              last_word
);

  logic [FREQ_W-1:0] master_clock_hz;
  logic              q_empty;
  logic              q_pop;
  entry_t            q_head;

  // The master clock register is the divisor of the tuning word.
  always_ff @(posedge clk) begin
    if (rst) begin
      master_clock_hz <= MASTER_CLOCK_RESET;
    end else if (config_write) begin
      master_clock_hz <= config_data;
    end
  end

  // The front end accepts and classifies requests and holds them in a short queue.
  dtcs_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .operation       (operation),
    .frequency_hz    (frequency_hz),
    .master_clock_hz (master_clock_hz),
    .pop             (q_pop),
    .busy            (busy),
    .empty           (q_empty),
    .head            (q_head)
  );

  // The back end divides where needed and plays out the command words.
  dtcs_back u_back (
    .clk             (clk),
    .rst             (rst),
    .empty           (q_empty),
    .head            (q_head),
    .master_clock_hz (master_clock_hz),
    .pop             (q_pop),
    .strobe          (strobe),
    .command_word    (command_word),
    .last_word       (last_word)
  );

endmodule

[test/dds_tuning_command_sequencer_top_tb.sv]
// Self-checking testbench for dds_tuning_command_sequencer_top.
// Depends on dtcs_pkg and the design files; it predicts every command word and checks
// the strobed words, in order, against that prediction.
module dds_tuning_command_sequencer_top_tb;
  import dtcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The longest run is a set frequency request with a full divide, and this many quiet
  // cycles are ample for the block to settle before a register write.
  localparam int unsigned SETTLE_CYCLES = 64;
  // Roughly 230 requests, plus idle gaps and pauses, fit well within this limit.
  localparam int unsigned CYCLE_LIMIT   = 300000;

  typedef struct {
    op_t               op;
    logic [FREQ_W-1:0] freq;
  } dds_request_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
  } command_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              start        = 1'b0;
  logic              busy;
  logic [1:0]        operation    = OP_INIT;
  logic [FREQ_W-1:0] frequency_hz = '0;
  logic              config_write = 1'b0;
  logic [FREQ_W-1:0] config_data  = '0;
  logic              strobe;
  logic [WORD_W-1:0] command_word;
  logic              last_word;

  dds_request_t      pending_requests[$];
  command_t          expected_words[$];
  logic [FREQ_W-1:0] clock_hz_model    = MASTER_CLOCK_RESET;
  int unsigned       sender_idle_pct   = 0;
  int unsigned       mismatch_count    = 0;
  int unsigned       cycle_count       = 0;
  dds_request_t      next_request;
  command_t          seen_word;

  dds_tuning_command_sequencer_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .frequency_hz (frequency_hz),
    .config_write (config_write),
    .config_data  (config_data),
    .strobe       (strobe),
    .command_word (command_word),
    .last_word    (last_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Tuning word as the synthesiser wants it: floor(freq * 2^32 / clock), saturating to
  // all ones whenever the frequency is at or above the clock. A zero clock therefore
  // always saturates and never divides.
  function automatic logic [FREQ_W-1:0] tuning_word_for(logic [FREQ_W-1:0] freq,
                                                        logic [FREQ_W-1:0] clock_hz);
    logic [63:0] quotient;
    if (freq >= clock_hz) begin
      return '1;
    end
    quotient = {freq, 32'd0} / {32'd0, clock_hz};
    return quotient[FREQ_W-1:0];
  endfunction

  function automatic void expect_word(logic [WORD_W-1:0] word, logic last);
    command_t c;
    c.word = word;
    c.last = last;
    expected_words.push_back(c);
  endfunction

  // Appends the run of command words that one accepted request should produce. The
  // frequency only matters to set frequency; the other operations ignore it.
  function automatic void queue_command_run(op_t op, logic [FREQ_W-1:0] freq);
    logic [FREQ_W-1:0] tw;
    case (op)
      OP_INIT: begin
        expect_word(WORD_RESET_CTRL, 1'b0);
        expect_word(WORD_CLEAR_A, 1'b0);
        expect_word(WORD_CLEAR_B, 1'b1);
      end
      OP_SET_FREQ: begin
        tw = tuning_word_for(freq, clock_hz_model);
        expect_word(WORD_FREQ_HH | {8'h00, tw[31:24]}, 1'b0);
        expect_word(WORD_FREQ_HL | {8'h00, tw[23:16]}, 1'b0);
        expect_word(WORD_FREQ_LH | {8'h00, tw[15:8]}, 1'b0);
        expect_word(WORD_FREQ_LL | {8'h00, tw[7:0]}, 1'b0);
        expect_word(WORD_PHASE_A, 1'b0);
        expect_word(WORD_PHASE_B, 1'b1);
      end
      OP_SLEEP_ON: begin
        expect_word(WORD_SLEEP_ON, 1'b1);
      end
      default: begin
        expect_word(WORD_CLEAR_B, 1'b1);
      end
    endcase
  endfunction

  function automatic void add_request(op_t op, logic [FREQ_W-1:0] freq);
    dds_request_t r;
    r.op   = op;
    r.freq = freq;
    pending_requests.push_back(r);
  endfunction

  // Frequencies for the random part. With a clock of tens of megahertz a uniform 32-bit
  // value nearly always saturates, so most picks are drawn below the current clock to
  // keep the divider busy, with the saturation boundary and the extremes mixed in.
  function automatic logic [FREQ_W-1:0] pick_frequency(logic [FREQ_W-1:0] clock_hz);
    logic [FREQ_W-1:0] f;
    case ($urandom_range(9))
      0:       f = $urandom;
      1:       f = '0;
      2:       f = '1;
      3:       f = clock_hz - 1;
      4:       f = clock_hz;
      5:       f = clock_hz + 1;
      default: f = (clock_hz == 0) ? $urandom : $urandom % clock_hz;
    endcase
    return f;
  endfunction

  // Set frequency is the only request with any arithmetic in it, so it takes over half
  // of the random requests; the other operations carry random, ignored frequencies.
  task automatic add_random_requests(int unsigned count);
    op_t op;
    repeat (count) begin
      op = ($urandom_range(1) == 1) ? OP_SET_FREQ : op_t'($urandom_range(3));
      add_request(op, pick_frequency(clock_hz_model));
    end
  endtask

  // Waits until every queued request has been taken and every predicted word has been
  // seen, then lets the block settle. Sampling on the falling edge keeps this clear of
  // the updates made by the driver and monitor on the rising edge.
  task automatic wait_until_drained();
    do begin
      @(negedge clk);
    end while (pending_requests.size() != 0 || start || expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The register is only written while no request is outstanding, so the model's copy
  // can simply follow the write.
  task automatic write_master_clock(logic [FREQ_W-1:0] value);
    @(posedge clk);
    config_write <= 1'b1;
    config_data  <= value;
    @(posedge clk);
    config_write <= 1'b0;
    clock_hz_model = value;
    @(negedge clk);
  endtask

  task automatic run_phase(logic [FREQ_W-1:0] clock_hz, int unsigned idle_pct,
                           int unsigned count);
    write_master_clock(clock_hz);
    sender_idle_pct = idle_pct;
    add_random_requests(count);
    wait_until_drained();
  endtask

  // Driver. A request transaction completes on an edge where start is high and busy is
  // low; until then the request is held. Between requests the sender idles at random
  // according to the current phase.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_request = pending_requests.pop_front();
        start        <= 1'b1;
        operation    <= next_request.op;
        frequency_hz <= next_request.freq;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. Prediction happens here too, on the very edge that completes a request
  // transaction, so the expected words are always queued before the check that follows
  // in the same block. Each strobed word is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        queue_command_run(op_t'(operation), frequency_hz);
      end
      if (strobe) begin
        if (expected_words.size() == 0) begin
          $error("unexpected command word: command_word=%h last_word=%b",
                 command_word, last_word);
          mismatch_count++;
        end else begin
          seen_word = expected_words.pop_front();
          if (command_word !== seen_word.word) begin
            $error("command_word: expected %h, actual %h", seen_word.word, command_word);
            mismatch_count++;
          end
          if (last_word !== seen_word.last) begin
            $error("last_word: expected %b, actual %b", seen_word.last, last_word);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost word ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dds_tuning_command_sequencer_top_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, at the reset clock of 25 MHz. A set frequency comes first, before
    // any init, to show that it simply uses the register as it stands.
    sender_idle_pct = 0;
    add_request(OP_SET_FREQ, 32'd1000000);
    add_request(OP_INIT, 32'hFFFF_FFFF);
    add_request(OP_SLEEP_ON, 32'hAAAA_AAAA);
    add_request(OP_SLEEP_OFF, 32'h5555_5555);
    add_request(OP_SET_FREQ, 32'd0);
    add_request(OP_SET_FREQ, 32'd1);
    add_request(OP_SET_FREQ, 32'd24999999);
    // Exactly at the clock and just above it: both saturate.
    add_request(OP_SET_FREQ, 32'd25000000);
    add_request(OP_SET_FREQ, 32'd25000001);
    add_request(OP_SET_FREQ, 32'hFFFF_FFFF);
    add_request(OP_SET_FREQ, 32'h8000_0000);
    // Half the clock gives a tuning word of exactly 0x80000000.
    add_request(OP_SET_FREQ, 32'd12500000);
    add_request(OP_SET_FREQ, 32'h00AB_CDEF);
    add_request(OP_INIT, 32'd0);
    add_request(OP_SLEEP_ON, 32'd0);
    add_request(OP_SLEEP_OFF, 32'hFFFF_FFFF);
    wait_until_drained();

    // A zero clock register must saturate every frequency, including zero itself.
    write_master_clock(32'd0);
    add_request(OP_SET_FREQ, 32'd0);
    add_request(OP_SET_FREQ, 32'd1);
    add_request(OP_SET_FREQ, 32'hFFFF_FFFF);
    add_request(OP_INIT, 32'd0);
    wait_until_drained();

    // Random part, in phases that differ in clock setting and in how often the sender
    // idles between requests. The phases with no idling keep the request queue full.
    run_phase(32'd100000000, 0, 40);
    run_phase(32'd1, 57, 30);
    run_phase(32'hFFFF_FFFF, 15, 40);
    run_phase(32'd0, 0, 20);
    run_phase($urandom, 57, 40);
    run_phase(MASTER_CLOCK_RESET, 15, 40);

    if (mismatch_count == 0) begin
      $display("dds_tuning_command_sequencer_top_tb passed");
    end else begin
      $display("dds_tuning_command_sequencer_top_tb failed");
    end
    $finish;
  end

endmodule
